@@ hdl/pcst_pkg.sv @@
`default_nettype none

package pcst_pkg;

  localparam int unsigned COLUMNS     = 24;
  localparam int unsigned CHIPS       = 10;
  localparam int unsigned CHANNELS    = 48;
  localparam int unsigned ERROR_TYPES = 16;

  localparam int unsigned PAD_DEPTH = COLUMNS * CHIPS * CHANNELS;
  localparam int unsigned PAD_AW    = (PAD_DEPTH > 1) ? $clog2(PAD_DEPTH) : 1;
  localparam int unsigned ETYPE_AW  = (ERROR_TYPES > 1) ? $clog2(ERROR_TYPES) : 1;

  localparam int unsigned COUNT_W = 32;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned SQ_W    = 64;
  localparam int unsigned CHARGE_W = 16;

  typedef enum logic [1:0] {
    OP_ADD_SAMPLE   = 2'd0,
    OP_COUNT_ERROR  = 2'd1,
    OP_CLEAR_PADS   = 2'd2,
    OP_CLEAR_ERRORS = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_PAD,
    RES_ERR,
    RES_BAD,
    RES_PLAIN
  } res_kind_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
    logic [SQ_W-1:0]    sq;
  } pad_entry_t;

  typedef struct packed {
    logic      latch;
    logic      mem_read;
    logic      pad_write;
    logic      sweep_write;
    logic      err_update;
    logic      err_clear;
    res_kind_t result;
  } pcst_cmd_t;

  typedef struct packed {
    op_t  op;
    logic pad_ok;
    logic etype_ok;
    logic sweep_last;
  } pcst_status_t;

  function automatic logic [31:0] inc_sat32(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

endpackage

`default_nettype wire

@@ hdl/pcst_ctrl.sv @@
`default_nettype none

module pcst_ctrl
  import pcst_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire pcst_status_t status,
  output pcst_cmd_t         cmd,
  output logic              busy,
  output logic              done
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_UPDATE,
    S_CLEAR
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.result = RES_NONE;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.sweep_write = 1'b1;
        if (status.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status.op)
          OP_ADD_SAMPLE: begin
            if (status.pad_ok) begin
              cmd.mem_read = 1'b1;
              state_next   = S_UPDATE;
            end else begin
              cmd.result = RES_BAD;
              state_next = S_IDLE;
            end
          end
          OP_COUNT_ERROR: begin
            if (status.etype_ok) begin
              cmd.err_update = 1'b1;
              cmd.result     = RES_ERR;
            end else begin
              cmd.result = RES_BAD;
            end
            state_next = S_IDLE;
          end
          OP_CLEAR_PADS: begin
            state_next = S_CLEAR;
          end
          OP_CLEAR_ERRORS: begin
            cmd.err_clear = 1'b1;
            cmd.result    = RES_PLAIN;
            state_next    = S_IDLE;
          end
        endcase
      end
      S_UPDATE: begin
        cmd.pad_write = 1'b1;
        cmd.result    = RES_PAD;
        state_next    = S_IDLE;
      end
      S_CLEAR: begin
        cmd.sweep_write = 1'b1;
        if (status.sweep_last) begin
          cmd.result = RES_PLAIN;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (cmd.result != RES_NONE);
    end
  end

  // a result always follows work, never an idle cycle
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != S_IDLE)
    else $error("result strobe without work in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> busy && !done)
    else $error("accepted request did not raise busy");

  a_init_silent: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT) |=> !done)
    else $error("result strobe during power-up clear");

endmodule

`default_nettype wire

@@ hdl/pcst_datapath.sv @@
`default_nettype none

module pcst_datapath
  import pcst_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pcst_cmd_t           cmd,
  input  wire logic [1:0]          op,
  input  wire logic [4:0]          column,
  input  wire logic [3:0]          chip,
  input  wire logic [5:0]          channel,
  input  wire logic [CHARGE_W-1:0] charge,
  input  wire logic [3:0]          error_type,
  output pcst_status_t             status,
  output logic [COUNT_W-1:0]       pad_count,
  output logic [SUM_W-1:0]         pad_sum,
  output logic [SQ_W-1:0]          pad_sum_squares,
  output logic [31:0]              type_error_count,
  output logic [31:0]              all_error_count,
  output logic                     index_error
);

  op_t                 op_q;
  logic [4:0]          column_q;
  logic [3:0]          chip_q;
  logic [5:0]          channel_q;
  logic [CHARGE_W-1:0] charge_q;
  logic [3:0]          etype_q;

  logic [PAD_AW-1:0]   pad_idx;
  logic [PAD_AW-1:0]   idx_q;
  logic [PAD_AW-1:0]   sweep;
  logic [2*CHARGE_W-1:0] sq_q;

  pad_entry_t pad_mem [PAD_DEPTH];
  pad_entry_t rd_q;
  pad_entry_t upd;
  pad_entry_t wdata;
  logic [PAD_AW-1:0] waddr;
  logic              we;

  logic [31:0]         hist [ERROR_TYPES];
  logic [31:0]         total;
  logic [31:0]         total_next;
  logic [31:0]         hist_inc;
  logic [ETYPE_AW-1:0] eidx;

  logic [SUM_W:0] sum_wide;
  logic [SQ_W:0]  sq_wide;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q      <= op_t'(op);
      column_q  <= column;
      chip_q    <= chip;
      channel_q <= channel;
      charge_q  <= charge;
      etype_q   <= error_type;
    end
  end

  assign pad_idx = PAD_AW'((32'(column_q) * CHIPS + 32'(chip_q)) * CHANNELS
                           + 32'(channel_q));
  assign eidx    = etype_q[ETYPE_AW-1:0];

  assign status.op         = op_q;
  assign status.pad_ok     = (32'(column_q) < COLUMNS) && (32'(chip_q) < CHIPS) &&
                             (32'(channel_q) < CHANNELS);
  assign status.etype_ok   = (32'(etype_q) < ERROR_TYPES);
  assign status.sweep_last = (32'(sweep) == PAD_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (rst || cmd.latch) begin
      sweep <= '0;
    end else if (cmd.sweep_write) begin
      sweep <= sweep + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      idx_q <= pad_idx;
      sq_q  <= (2*CHARGE_W)'(charge_q) * (2*CHARGE_W)'(charge_q);
    end
  end

  assign sum_wide  = {1'b0, rd_q.sum} + (SUM_W + 1)'(charge_q);
  assign sq_wide   = {1'b0, rd_q.sq} + (SQ_W + 1)'(sq_q);
  assign upd.count = inc_sat32(rd_q.count);
  assign upd.sum   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
  assign upd.sq    = sq_wide[SQ_W] ? '1 : sq_wide[SQ_W-1:0];

  assign we    = cmd.pad_write || cmd.sweep_write;
  assign waddr = cmd.sweep_write ? sweep : idx_q;
  assign wdata = cmd.sweep_write ? '0 : upd;

  always_ff @(posedge clk) begin
    if (we) begin
      pad_mem[waddr] <= wdata;
    end
    if (cmd.mem_read) begin
      rd_q <= pad_mem[pad_idx];
    end
  end

  assign hist_inc = inc_sat32(hist[eidx]);

  always_comb begin
    priority if (cmd.err_clear) begin
      total_next = '0;
    end else if (cmd.err_update) begin
      total_next = inc_sat32(total);
    end else begin
      total_next = total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.err_clear) begin
      for (int i = 0; i < ERROR_TYPES; i++) begin
        hist[i] <= '0;
      end
      total <= '0;
    end else begin
      if (cmd.err_update) begin
        hist[eidx] <= hist_inc;
      end
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_count        <= '0;
      pad_sum          <= '0;
      pad_sum_squares  <= '0;
      type_error_count <= '0;
      all_error_count  <= '0;
      index_error      <= 1'b0;
    end else begin
      unique case (cmd.result)
        RES_NONE: begin
        end
        RES_PAD: begin
          pad_count        <= upd.count;
          pad_sum          <= upd.sum;
          pad_sum_squares  <= upd.sq;
          type_error_count <= '0;
          all_error_count  <= total_next;
          index_error      <= 1'b0;
        end
        RES_ERR: begin
          pad_count        <= '0;
          pad_sum          <= '0;
          pad_sum_squares  <= '0;
          type_error_count <= hist_inc;
          all_error_count  <= total_next;
          index_error      <= 1'b0;
        end
        RES_BAD: begin
          pad_count        <= '0;
          pad_sum          <= '0;
          pad_sum_squares  <= '0;
          type_error_count <= '0;
          all_error_count  <= total_next;
          index_error      <= 1'b1;
        end
        RES_PLAIN: begin
          pad_count        <= '0;
          pad_sum          <= '0;
          pad_sum_squares  <= '0;
          type_error_count <= '0;
          all_error_count  <= total_next;
          index_error      <= 1'b0;
        end
      endcase
    end
  end

  a_bad_index_clean: assert property (@(posedge clk) disable iff (rst)
    index_error |-> (pad_count == '0) && (pad_sum == '0) &&
                    (pad_sum_squares == '0) && (type_error_count == '0))
    else $error("index error result carries data");

  a_err_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.err_clear |=> (total == '0) && (all_error_count == '0))
    else $error("error clear left a nonzero total");

  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    !(cmd.pad_write && cmd.sweep_write) && !(cmd.mem_read && we))
    else $error("pad memory access conflict");

endmodule

`default_nettype wire

@@ hdl/pad_charge_statistics_table_unit.sv @@
// Per-pad charge statistics (count, charge sum, sum of squares) plus a decoding
// error histogram and total. A request is taken when start is high and busy low;
// each request yields one result, shown for one cycle with done high, and must be
// captured then since it cannot be held off. An add-sample request keeps the unit
// busy through a decode state, which reads the single-port pad RAM, and an update
// state, which writes it back; error count, error clear and bad-index requests are
// done in the decode state alone. No new request is taken until busy falls again.
// A pad table clear keeps the unit busy through the decode state and then a sweep
// of all 11520 pad RAM entries, one entry per cycle, before its result. After reset
// the same clearing pass runs with busy high and no result.
`default_nettype none

module pad_charge_statistics_table_unit
  import pcst_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          op,
  input  wire logic [4:0]          column,
  input  wire logic [3:0]          chip,
  input  wire logic [5:0]          channel,
  input  wire logic [CHARGE_W-1:0] charge,
  input  wire logic [3:0]          error_type,
  output logic                     done,
  output logic [COUNT_W-1:0]       pad_count,
  output logic [SUM_W-1:0]         pad_sum,
  output logic [SQ_W-1:0]          pad_sum_squares,
  output logic [31:0]              type_error_count,
  output logic [31:0]              all_error_count,
  output logic                     index_error
);

  pcst_cmd_t    cmd;
  pcst_status_t status;

  pcst_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  pcst_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .op               (op),
    .column           (column),
    .chip             (chip),
    .channel          (channel),
    .charge           (charge),
    .error_type       (error_type),
    .status           (status),
    .pad_count        (pad_count),
    .pad_sum          (pad_sum),
    .pad_sum_squares  (pad_sum_squares),
    .type_error_count (type_error_count),
    .all_error_count  (all_error_count),
    .index_error      (index_error)
  );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import pcst_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int N_RANDOM     = 650;
  localparam int MAX_CLEARS   = 10;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOT_PADS     = 8;

  typedef struct {
    op_t        op;
    logic [4:0] column;
    logic [3:0] chip;
    logic [5:0] channel;
    logic [15:0] charge;
    logic [3:0] error_type;
  } stat_req_t;

  typedef struct {
    logic [COUNT_W-1:0] pad_count;
    logic [SUM_W-1:0]   pad_sum;
    logic [SQ_W-1:0]    pad_sum_squares;
    logic [31:0]        type_error_count;
    logic [31:0]        all_error_count;
    logic               index_error;
  } stat_res_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [1:0]          op = '0;
  logic [4:0]          column = '0;
  logic [3:0]          chip = '0;
  logic [5:0]          channel = '0;
  logic [CHARGE_W-1:0] charge = '0;
  logic [3:0]          error_type = '0;
  logic                busy;
  logic                done;
  logic [COUNT_W-1:0]  pad_count;
  logic [SUM_W-1:0]    pad_sum;
  logic [SQ_W-1:0]     pad_sum_squares;
  logic [31:0]         type_error_count;
  logic [31:0]         all_error_count;
  logic                index_error;

  pad_charge_statistics_table_unit uut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .op               (op),
    .column           (column),
    .chip             (chip),
    .channel          (channel),
    .charge           (charge),
    .error_type       (error_type),
    .done             (done),
    .pad_count        (pad_count),
    .pad_sum          (pad_sum),
    .pad_sum_squares  (pad_sum_squares),
    .type_error_count (type_error_count),
    .all_error_count  (all_error_count),
    .index_error      (index_error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the statistics stores
  logic [COUNT_W-1:0] count_shadow [PAD_DEPTH];
  logic [SUM_W-1:0]   sum_shadow   [PAD_DEPTH];
  logic [SQ_W-1:0]    sq_shadow    [PAD_DEPTH];
  logic [31:0]        hist_shadow  [ERROR_TYPES];
  logic [31:0]        total_shadow;

  stat_req_t req_q [$];
  stat_res_t stats_due [$];

  int   errors = 0;
  int   cycle_count = 0;
  int   n_issued = 0;
  int   n_accepted = 0;
  int   n_add = 0, n_bad = 0, n_errcnt = 0, n_clr_pads = 0, n_clr_errs = 0;
  int   idle_left = 0;
  int   burst_left = 0;
  logic taken = 1'b0;

  function automatic logic [31:0] bump32(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void wipe_pads();
    for (int i = 0; i < PAD_DEPTH; i++) begin
      count_shadow[i] = '0;
      sum_shadow[i]   = '0;
      sq_shadow[i]    = '0;
    end
  endfunction

  function automatic void wipe_errors();
    for (int i = 0; i < ERROR_TYPES; i++) hist_shadow[i] = '0;
    total_shadow = '0;
  endfunction

  function automatic stat_res_t update_stats(stat_req_t r);
    stat_res_t  res;
    int         idx;
    logic [SUM_W:0] sum_w;
    logic [SQ_W:0]  sq_w;
    logic [31:0]    chg_sq;
    res = '{default: '0};
    case (r.op)
      OP_ADD_SAMPLE: begin
        if (r.column >= COLUMNS || r.chip >= CHIPS || r.channel >= CHANNELS) begin
          res.index_error = 1'b1;
        end else begin
          idx = (int'(r.column) * CHIPS + int'(r.chip)) * CHANNELS + int'(r.channel);
          chg_sq = r.charge * r.charge;
          count_shadow[idx] = bump32(count_shadow[idx]);
          sum_w = {1'b0, sum_shadow[idx]} + r.charge;
          sum_shadow[idx] = sum_w[SUM_W] ? '1 : sum_w[SUM_W-1:0];
          sq_w = {1'b0, sq_shadow[idx]} + chg_sq;
          sq_shadow[idx] = sq_w[SQ_W] ? '1 : sq_w[SQ_W-1:0];
          res.pad_count       = count_shadow[idx];
          res.pad_sum         = sum_shadow[idx];
          res.pad_sum_squares = sq_shadow[idx];
        end
      end
      OP_COUNT_ERROR: begin
        if (r.error_type >= ERROR_TYPES) begin
          res.index_error = 1'b1;
        end else begin
          hist_shadow[r.error_type] = bump32(hist_shadow[r.error_type]);
          total_shadow = bump32(total_shadow);
          res.type_error_count = hist_shadow[r.error_type];
        end
      end
      OP_CLEAR_PADS:   wipe_pads();
      OP_CLEAR_ERRORS: wipe_errors();
      default: ;
    endcase
    res.all_error_count = total_shadow;
    return res;
  endfunction

  function automatic void queue_req(op_t o, int col, int chp, int ch, int chg, int et);
    stat_req_t r;
    r.op         = o;
    r.column     = col[4:0];
    r.chip       = chp[3:0];
    r.channel    = ch[5:0];
    r.charge     = chg[15:0];
    r.error_type = et[3:0];
    req_q.push_back(r);
    n_issued++;
  endfunction

  function automatic int pick_charge();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return 16'hFFFF;
    return $urandom_range(0, 16'hFFFF);
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // driver: presents the next request at the falling edge
  always @(negedge clk) begin : drive_req
    stat_req_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (req_q.size() > 0) begin
        nxt = req_q.pop_front();
        op         <= nxt.op;
        column     <= nxt.column;
        chip       <= nxt.chip;
        channel    <= nxt.channel;
        charge     <= nxt.charge;
        error_type <= nxt.error_type;
        start      <= 1'b1;
        idle_left  = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predicts on acceptance, checks each strobed result
  always @(posedge clk) begin : watch_results
    stat_req_t cur;
    stat_res_t want;
    taken <= !rst && start && !busy;
    if (!rst && start && !busy) begin
      cur.op         = op_t'(op);
      cur.column     = column;
      cur.chip       = chip;
      cur.channel    = channel;
      cur.charge     = charge;
      cur.error_type = error_type;
      want = update_stats(cur);
      stats_due.push_back(want);
      n_accepted++;
      case (cur.op)
        OP_ADD_SAMPLE:   n_add++;
        OP_COUNT_ERROR:  n_errcnt++;
        OP_CLEAR_PADS:   n_clr_pads++;
        default:         n_clr_errs++;
      endcase
      if (want.index_error) n_bad++;
    end
    if (!rst && done) begin
      if (stats_due.size() == 0) begin
        $error("result strobed with no request outstanding");
        errors++;
      end else begin
        want = stats_due.pop_front();
        if (pad_count !== want.pad_count) begin
          $error("pad_count: expected %0d, got %0d", want.pad_count, pad_count);
          errors++;
        end
        if (pad_sum !== want.pad_sum) begin
          $error("pad_sum: expected %0d, got %0d", want.pad_sum, pad_sum);
          errors++;
        end
        if (pad_sum_squares !== want.pad_sum_squares) begin
          $error("pad_sum_squares: expected %0d, got %0d",
                 want.pad_sum_squares, pad_sum_squares);
          errors++;
        end
        if (type_error_count !== want.type_error_count) begin
          $error("type_error_count: expected %0d, got %0d",
                 want.type_error_count, type_error_count);
          errors++;
        end
        if (all_error_count !== want.all_error_count) begin
          $error("all_error_count: expected %0d, got %0d",
                 want.all_error_count, all_error_count);
          errors++;
        end
        if (index_error !== want.index_error) begin
          $error("index_error: expected %0d, got %0d", want.index_error, index_error);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("tb failed");
    $finish;
  end

  initial begin : stimulus
    int hot_col [HOT_PADS];
    int hot_chip [HOT_PADS];
    int hot_chan [HOT_PADS];
    int clears;
    int r;
    int k;
    wipe_pads();
    wipe_errors();

    // directed: corners, out-of-range pads, every op
    queue_req(OP_ADD_SAMPLE, 0, 0, 0, 0, 0);
    queue_req(OP_ADD_SAMPLE, 0, 0, 0, 16'hFFFF, 15);
    queue_req(OP_ADD_SAMPLE, COLUMNS-1, CHIPS-1, CHANNELS-1, 16'hFFFF, 0);
    queue_req(OP_ADD_SAMPLE, COLUMNS-1, CHIPS-1, CHANNELS-1, 1, 0);
    queue_req(OP_ADD_SAMPLE, COLUMNS, 0, 0, 100, 0);
    queue_req(OP_ADD_SAMPLE, 31, 15, 63, 16'hFFFF, 15);
    queue_req(OP_ADD_SAMPLE, 5, CHIPS, 3, 200, 0);
    queue_req(OP_ADD_SAMPLE, 5, 3, CHANNELS, 300, 0);
    queue_req(OP_COUNT_ERROR, 31, 15, 63, 16'hFFFF, 0);
    queue_req(OP_COUNT_ERROR, 0, 0, 0, 0, 15);
    queue_req(OP_COUNT_ERROR, 0, 0, 0, 0, 15);
    queue_req(OP_ADD_SAMPLE, 0, 0, 0, 16'h5555, 0);
    queue_req(OP_CLEAR_ERRORS, 31, 15, 63, 16'hFFFF, 15);
    queue_req(OP_COUNT_ERROR, 0, 0, 0, 0, 7);
    queue_req(OP_CLEAR_PADS, 31, 15, 63, 16'hFFFF, 15);
    queue_req(OP_ADD_SAMPLE, 0, 0, 0, 16'hAAAA, 0);
    queue_req(OP_ADD_SAMPLE, COLUMNS-1, CHIPS-1, CHANNELS-1, 16'h8000, 0);
    queue_req(OP_COUNT_ERROR, 0, 0, 0, 0, 3);
    clears = 1;

    // random: mostly samples on a few hot pads so the sums build up
    for (int i = 0; i < HOT_PADS; i++) begin
      hot_col[i]  = $urandom_range(0, COLUMNS-1);
      hot_chip[i] = $urandom_range(0, CHIPS-1);
      hot_chan[i] = $urandom_range(0, CHANNELS-1);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(0, 999);
      if (r < 8 && clears < MAX_CLEARS) begin
        queue_req(OP_CLEAR_PADS, $urandom_range(0, 31), $urandom_range(0, 15),
                  $urandom_range(0, 63), $urandom_range(0, 16'hFFFF), $urandom_range(0, 15));
        clears++;
      end else if (r < 25) begin
        queue_req(OP_CLEAR_ERRORS, $urandom_range(0, 31), $urandom_range(0, 15),
                  $urandom_range(0, 63), $urandom_range(0, 16'hFFFF), $urandom_range(0, 15));
      end else if (r < 225) begin
        queue_req(OP_COUNT_ERROR, $urandom_range(0, 31), $urandom_range(0, 15),
                  $urandom_range(0, 63), $urandom_range(0, 16'hFFFF), $urandom_range(0, 15));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          k = $urandom_range(0, HOT_PADS-1);
          queue_req(OP_ADD_SAMPLE, hot_col[k], hot_chip[k], hot_chan[k], pick_charge(),
                    $urandom_range(0, 15));
        end else if (r < 95) begin
          queue_req(OP_ADD_SAMPLE, $urandom_range(0, COLUMNS-1), $urandom_range(0, CHIPS-1),
                    $urandom_range(0, CHANNELS-1), pick_charge(), $urandom_range(0, 15));
        end else begin
          k = $urandom_range(0, 2);
          queue_req(OP_ADD_SAMPLE,
                    (k == 0) ? $urandom_range(COLUMNS, 31) : $urandom_range(0, 31),
                    (k == 1) ? $urandom_range(CHIPS, 15) : $urandom_range(0, 15),
                    (k == 2) ? $urandom_range(CHANNELS, 63) : $urandom_range(0, 63),
                    pick_charge(), $urandom_range(0, 15));
        end
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (n_accepted != n_issued) @(posedge clk);
    while (stats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests: %0d sample adds (%0d bad index), %0d error counts,",
             n_accepted, n_add, n_bad, n_errcnt);
    $display("%0d pad table clears, %0d error clears, %0d cycles",
             n_clr_pads, n_clr_errs, cycle_count);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/pcst_pkg.sv
hdl/pcst_ctrl.sv
hdl/pcst_datapath.sv
hdl/pad_charge_statistics_table_unit.sv
tb/tb.sv
